// ----- sv/point_figure_rotate_scale_plot_defines.svh -----
// Assertion macros for the point figure rotate/scale/plot block.
// Used by the top level only; no other dependencies.
`ifndef POINT_FIGURE_ROTATE_SCALE_PLOT_DEFINES_SVH
`define POINT_FIGURE_ROTATE_SCALE_PLOT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PFRSP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define PFRSP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/pfrsp_pkg.sv -----
// Package for the point figure rotate/scale/plot block: transaction structs,
// codes, state encoding and the fixed-point helper functions. No dependencies.
package pfrsp_pkg;

   localparam int DEF_MAX_POINTS = 64;
   localparam int SPRITE_COLS    = 64;
   localparam int SPRITE_ROWS    = 64;

   localparam int COORD_W = 24;
   localparam int OPA_W   = 25;
   localparam int OPB_W   = 16;
   localparam int PROD_W  = 41;
   localparam int ACC_W   = 42;
   localparam int PIX_W   = 16;
   localparam int PXF_W   = 26;
   localparam int CSR_IDX_W = 1;

   // action codes
   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_KEY    = 2'd2;
   localparam logic [1:0] ACT_DRAW   = 2'd3;

   // key codes (ASCII)
   localparam logic [7:0] KEY_ZOOM_OUT = 8'd45;
   localparam logic [7:0] KEY_ZOOM_IN  = 8'd43;
   localparam logic [7:0] KEY_LEFT     = 8'd52;
   localparam logic [7:0] KEY_RIGHT    = 8'd54;
   localparam logic [7:0] KEY_UP       = 8'd56;
   localparam logic [7:0] KEY_DOWN     = 8'd50;
   localparam logic [7:0] KEY_ROT_NEG  = 8'd55;
   localparam logic [7:0] KEY_ROT_POS  = 8'd57;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_X = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_Y = 1'b1;

   // Q2.14 cos/sin of 30*3.14/180, Q7.8 zoom step of 0.3
   localparam logic signed [OPB_W-1:0] COS30_Q14 = 16'sd14191;
   localparam logic signed [OPB_W-1:0] SIN30_Q14 = 16'sd8188;
   localparam logic signed [7:0]       ZOOM_STEP = 8'sd77;
   localparam logic signed [7:0]       OFS_STEP  = 8'sd1;
   localparam logic signed [PIX_W-1:0] ZOOM_ONE  = 16'sd256;

   typedef struct packed {
      logic [1:0]                 action;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic [7:0]                 key_code;
   } req_type;

   typedef struct packed {
      logic signed [PIX_W-1:0] pixel_x;
      logic signed [PIX_W-1:0] pixel_y;
      logic                    visible;
      logic                    last;
   } rsp_type;

   // control of the shared multiply/accumulate unit
   typedef struct packed {
      logic acc_load;
      logic acc_add;
   } mac_ctl_type;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_READ = 9'b000000010,
      ST_LOAD = 9'b000000100,
      ST_MUL0 = 9'b000001000,
      ST_MUL1 = 9'b000010000,
      ST_MUL2 = 9'b000100000,
      ST_MUL3 = 9'b001000000,
      ST_MUL4 = 9'b010000000,
      ST_MUL5 = 9'b100000000
   } state_type;

   // 16-bit signed add of a small step, saturating
   function automatic logic signed [PIX_W-1:0] sat_step16(
      input logic signed [PIX_W-1:0] v,
      input logic signed [7:0]       step);
      logic signed [PIX_W:0] s;
      s = 17'(v) + 17'(step);
      if (s > 17'sd32767) begin
         return 16'sh7FFF;
      end else if (s < -17'sd32768) begin
         return 16'sh8000;
      end
      return 16'(s);
   endfunction

   // saturate the exact pixel value to 16 bits
   function automatic logic signed [PIX_W-1:0] sat_pix(input logic signed [PXF_W-1:0] v);
      if (v > 26'sd32767) begin
         return 16'sh7FFF;
      end else if (v < -26'sd32768) begin
         return 16'sh8000;
      end
      return 16'(v);
   endfunction

   // Q.22 accumulator -> nearest Q.8 (ties up), add pivot, saturate to 24 bits
   function automatic logic signed [COORD_W-1:0] rot_finish(
      input logic signed [ACC_W-1:0]   acc,
      input logic signed [COORD_W-1:0] pivot);
      logic signed [ACC_W-1:0] biased;
      logic signed [27:0]      rnd;
      logic signed [28:0]      sum;
      biased = acc + 42'sd8192;
      rnd    = 28'(biased >>> 14);
      sum    = 29'(rnd) + 29'(pivot);
      if (sum > 29'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (sum < -29'sd8388608) begin
         return 24'sh800000;
      end
      return 24'(sum);
   endfunction

   // Q15.8 -> integer: toward zero, but up when a positive fraction exceeds one half
   function automatic logic signed [16:0] to_pixel_int(input logic signed [COORD_W-1:0] v);
      logic signed [COORD_W:0] vb;
      logic signed [16:0]      q;
      if (v[COORD_W-1]) begin
         vb = 25'(v) + 25'sd255;
         q  = 17'(vb >>> 8);
      end else begin
         q = 17'(v >>> 8);
         if (v[7:0] > 8'd128) begin
            q = q + 17'sd1;
         end
      end
      return q;
   endfunction

   // product / 256 toward zero, plus offset
   function automatic logic signed [PXF_W-1:0] draw_scale(
      input logic signed [PROD_W-1:0] prod,
      input logic signed [PIX_W-1:0]  ofs);
      logic signed [32:0] p;
      logic signed [24:0] q;
      p = 33'(prod);
      if (p[32]) begin
         p = p + 33'sd255;
      end
      q = 25'(p >>> 8);
      return 26'(q) + 26'(ofs);
   endfunction

endpackage

// ----- sv/point_figure_rotate_scale_plot.sv -----
// Point figure store with zoom/offset/rotate key commands and draw; one shared MAC.
// Clear, append and non-rotate keys finish at the accepting edge; busy stays low.
// Rotate, per stored point: RAM read, operand load, 4 multiplies + finish.
// Draw, per point: RAM read, operand load, x and y multiplies, then a registered result strobe.
// Synchronous active-high reset clears count, zoom (1.0), offsets and pivots.
`include "point_figure_rotate_scale_plot_defines.svh"
module point_figure_rotate_scale_plot #(
   parameter int MAX_POINTS = pfrsp_pkg::DEF_MAX_POINTS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  pfrsp_pkg::req_type                     req_data,
   output logic                                   rsp_strobe,
   output pfrsp_pkg::rsp_type                     rsp_data,
   input  logic                                   csr_we,
   input  logic [pfrsp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pfrsp_pkg::COORD_W-1:0]          csr_wdata
);
   import pfrsp_pkg::*;

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int RAM_W = 2 * COORD_W;

   state_type                 state_ff, state_in;
   logic                      rot_ff, rot_in;
   logic signed [OPB_W-1:0]   sin_ff, sin_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [PIX_W-1:0]   zoom_ff, zoom_in;
   logic signed [PIX_W-1:0]   ofsx_ff, ofsx_in;
   logic signed [PIX_W-1:0]   ofsy_ff, ofsy_in;
   logic signed [COORD_W-1:0] pivx_ff, pivx_in;
   logic signed [COORD_W-1:0] pivy_ff, pivy_in;
   logic signed [OPA_W-1:0]   opa_ff, opa_in;
   logic signed [OPA_W-1:0]   opb_ff, opb_in;
   logic signed [COORD_W-1:0] newx_ff, newx_in;
   logic signed [PXF_W-1:0]   px_ff, px_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic                      ram_we;
   logic [IDX_W-1:0]          ram_waddr;
   logic [RAM_W-1:0]          ram_wdata;
   logic                      ram_re;
   logic [RAM_W-1:0]          ram_rdata;
   logic signed [COORD_W-1:0] rd_x;
   logic signed [COORD_W-1:0] rd_y;

   mac_ctl_type               mac_ctl;
   logic signed [OPA_W-1:0]   mac_a;
   logic signed [OPB_W-1:0]   mac_b;
   logic signed [PROD_W-1:0]  mac_prod;
   logic signed [ACC_W-1:0]   mac_acc;

   logic signed [PXF_W-1:0]   py_full;
   logic                      last_pt;

   // point store: {x, y} per entry
   pfrsp_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   pfrsp_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .prod  (mac_prod),
      .acc   (mac_acc)
   );

   assign rd_x    = ram_rdata[RAM_W-1:COORD_W];
   assign rd_y    = ram_rdata[COORD_W-1:0];
   assign py_full = draw_scale(mac_prod, ofsy_ff);
   assign last_pt = (CNT_W'(idx_ff) == (count_ff - CNT_W'(1)));

   // sequencer and datapath control
   always_comb begin
      state_in      = state_ff;
      rot_in        = rot_ff;
      sin_in        = sin_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      zoom_in       = zoom_ff;
      ofsx_in       = ofsx_ff;
      ofsy_in       = ofsy_ff;
      pivx_in       = pivx_ff;
      pivy_in       = pivy_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      newx_in       = newx_ff;
      px_in         = px_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = count_ff[IDX_W-1:0];
      ram_wdata     = {req_data.point_x, req_data.point_y};
      ram_re        = 1'b0;
      mac_ctl       = '0;
      mac_a         = opa_ff;
      mac_b         = COS30_Q14;

      // register writes
      if (csr_we) begin
         case (csr_index)
            CSR_PIVOT_X: pivx_in = csr_wdata;
            CSR_PIVOT_Y: pivy_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.action)
                  ACT_CLEAR: count_in = '0;
                  ACT_APPEND: begin
                     if (count_ff < CNT_W'(MAX_POINTS)) begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_KEY: begin
                     case (req_data.key_code)
                        KEY_ZOOM_OUT: zoom_in = sat_step16(zoom_ff, -ZOOM_STEP);
                        KEY_ZOOM_IN:  zoom_in = sat_step16(zoom_ff, ZOOM_STEP);
                        KEY_LEFT:     ofsx_in = sat_step16(ofsx_ff, -OFS_STEP);
                        KEY_RIGHT:    ofsx_in = sat_step16(ofsx_ff, OFS_STEP);
                        KEY_UP:       ofsy_in = sat_step16(ofsy_ff, -OFS_STEP);
                        KEY_DOWN:     ofsy_in = sat_step16(ofsy_ff, OFS_STEP);
                        KEY_ROT_NEG, KEY_ROT_POS: begin
                           sin_in = (req_data.key_code == KEY_ROT_POS) ?
                                    SIN30_Q14 : -SIN30_Q14;
                           if (count_ff != '0) begin
                              rot_in   = 1'b1;
                              idx_in   = '0;
                              state_in = ST_READ;
                           end
                        end
                        default: ;
                     endcase
                  end
                  ACT_DRAW: begin
                     if (count_ff != '0) begin
                        rot_in   = 1'b0;
                        idx_in   = '0;
                        state_in = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_LOAD;
         end

         // operands: pivot-relative for rotate, rounded integers for draw
         ST_LOAD: begin
            if (rot_ff) begin
               opa_in = OPA_W'(rd_x) - OPA_W'(pivx_ff);
               opb_in = OPA_W'(rd_y) - OPA_W'(pivy_ff);
            end else begin
               opa_in = OPA_W'(to_pixel_int(rd_x));
               opb_in = OPA_W'(to_pixel_int(rd_y));
            end
            state_in = ST_MUL0;
         end

         ST_MUL0: begin
            mac_a    = opa_ff;
            mac_b    = rot_ff ? COS30_Q14 : zoom_ff;
            state_in = ST_MUL1;
         end

         ST_MUL1: begin
            mac_a = opb_ff;
            if (rot_ff) begin
               mac_b           = -sin_ff;
               mac_ctl.acc_load = 1'b1;
            end else begin
               mac_b = zoom_ff;
               px_in = draw_scale(mac_prod, ofsx_ff);
            end
            state_in = ST_MUL2;
         end

         ST_MUL2: begin
            if (rot_ff) begin
               mac_a           = opa_ff;
               mac_b           = sin_ff;
               mac_ctl.acc_add = 1'b1;
               state_in        = ST_MUL3;
            end else begin
               // emit one draw result
               rsp_strobe_in       = 1'b1;
               rsp_data_in.pixel_x = sat_pix(px_ff);
               rsp_data_in.pixel_y = sat_pix(py_full);
               rsp_data_in.visible = !px_ff[PXF_W-1] &&
                                     (px_ff < $signed(PXF_W'(SPRITE_COLS))) &&
                                     !py_full[PXF_W-1] &&
                                     (py_full < $signed(PXF_W'(SPRITE_ROWS)));
               rsp_data_in.last    = last_pt;
               if (last_pt) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_READ;
               end
            end
         end

         // accumulator holds new x offset
         ST_MUL3: begin
            mac_a            = opb_ff;
            mac_b            = COS30_Q14;
            mac_ctl.acc_load = 1'b1;
            newx_in          = rot_finish(mac_acc, pivx_ff);
            state_in         = ST_MUL4;
         end

         ST_MUL4: begin
            mac_ctl.acc_add = 1'b1;
            state_in        = ST_MUL5;
         end

         // accumulator holds new y offset: write the point back
         ST_MUL5: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = {newx_ff, rot_finish(mac_acc, pivy_ff)};
            if (last_pt) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_READ;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rot_ff        <= 1'b0;
         idx_ff        <= '0;
         count_ff      <= '0;
         zoom_ff       <= ZOOM_ONE;
         ofsx_ff       <= '0;
         ofsy_ff       <= '0;
         pivx_ff       <= '0;
         pivy_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rot_ff        <= rot_in;
         idx_ff        <= idx_in;
         count_ff      <= count_in;
         zoom_ff       <= zoom_in;
         ofsx_ff       <= ofsx_in;
         ofsy_ff       <= ofsy_in;
         pivx_ff       <= pivx_in;
         pivy_ff       <= pivy_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sin_ff      <= sin_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      newx_ff     <= newx_in;
      px_ff       <= px_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // checks
   `PFRSP_ASSERT_NXT(a_strobe_gap, clock, reset, rsp_strobe, !rsp_strobe, "result strobes too close")
   `PFRSP_ASSERT_NXT(a_emit_strobe, clock, reset, (state_ff == ST_MUL2) && !rot_ff, rsp_strobe, "draw step gave no strobe")
   `PFRSP_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_POINTS), "point count past store depth")
   `PFRSP_ASSERT_NXT(a_empty_draw, clock, reset, start && !busy && (req_data.action == ACT_DRAW) && (count_ff == '0), !busy, "empty draw went busy")

endmodule

// ----- sv/pfrsp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Self-contained; no package dependencies.
module pfrsp_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port, holds when not reading
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/pfrsp_mac.sv -----
// Shared signed multiply/accumulate unit: registered product, then accumulator.
// Depends on pfrsp_pkg for widths and the control struct.
module pfrsp_mac (
   input  logic                                      clock,
   input  pfrsp_pkg::mac_ctl_type                    ctl,
   input  logic signed [pfrsp_pkg::OPA_W-1:0]        op_a,
   input  logic signed [pfrsp_pkg::OPB_W-1:0]        op_b,
   output logic signed [pfrsp_pkg::PROD_W-1:0]       prod,
   output logic signed [pfrsp_pkg::ACC_W-1:0]        acc
);
   import pfrsp_pkg::*;

   logic signed [PROD_W-1:0] a_ext;
   logic signed [PROD_W-1:0] b_ext;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   // multiply stage
   assign a_ext   = PROD_W'(op_a);
   assign b_ext   = PROD_W'(op_b);
   assign prod_in = a_ext * b_ext;

   // accumulate stage works on the previous product
   always_comb begin
      acc_in = acc_ff;
      if (ctl.acc_load) begin
         acc_in = ACC_W'(prod_ff);
      end else if (ctl.acc_add) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

// ----- dv/tb_point_figure_rotate_scale_plot.sv -----
// Testbench for point_figure_rotate_scale_plot: directed, saturation and random transactions
// checked against an in-bench model of the point store, zoom, offsets, rotation and draw.
// Depends on pfrsp_pkg and the block's RTL only.
`timescale 1ns / 1ps
module tb_point_figure_rotate_scale_plot;
   import pfrsp_pkg::*;

   localparam logic [7:0] KEY_SET [8] = '{KEY_ZOOM_OUT, KEY_ZOOM_IN, KEY_LEFT, KEY_RIGHT,
                                         KEY_UP, KEY_DOWN, KEY_ROT_NEG, KEY_ROT_POS};
   localparam int SEND_IDLE_PCT [4] = '{0, 66, 0, 11};
   localparam int PHASE_ITEMS = 40;
   localparam int SETTLE_CYCLES = 600;    // room for a full 64-point rotation, plus slack
   localparam int DRAIN_CYCLES = 4000;
   localparam int ERR_REPORT_MAX = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COORD_W-1:0] csr_wdata = '0;

   // pending transactions, expected draw results
   req_type cmd_pend_q [$];
   rsp_type pixel_expect_q [$];
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int counted_items = 0;
   int gen_points = 0;

   // model state
   longint fig_x [DEF_MAX_POINTS];
   longint fig_y [DEF_MAX_POINTS];
   int fig_count;
   longint zoom_q8, ofs_x, ofs_y, piv_x, piv_y;

   point_figure_rotate_scale_plot dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------- model ----------------
   function automatic longint clamp_signed(input longint v, input int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   // Q15.8 to integer: toward zero, up when a positive fraction is above one half
   function automatic longint to_whole(input longint v);
      if (v >= 0) begin
         return v / 256 + (((v % 256) > 128) ? 1 : 0);
      end
      return -((-v) / 256);
   endfunction

   task automatic rotate_figure(input longint s);
      longint dx, dy, nx, ny, c;
      c = longint'(COS30_Q14);
      for (int i = 0; i < fig_count; i++) begin
         dx = fig_x[i] - piv_x;
         dy = fig_y[i] - piv_y;
         nx = dx * c - dy * s;
         ny = dx * s + dy * c;
         // nearest Q.8, ties toward +inf
         fig_x[i] = clamp_signed(((nx + 8192) >>> 14) + piv_x, COORD_W);
         fig_y[i] = clamp_signed(((ny + 8192) >>> 14) + piv_y, COORD_W);
      end
   endtask

   task automatic plot_predict(input req_type r);
      longint px, py;
      rsp_type pix;
      case (r.action)
         ACT_CLEAR: fig_count = 0;
         ACT_APPEND: begin
            if (fig_count < DEF_MAX_POINTS) begin
               fig_x[fig_count] = longint'(r.point_x);
               fig_y[fig_count] = longint'(r.point_y);
               fig_count++;
            end
         end
         ACT_KEY: begin
            case (r.key_code)
               KEY_ZOOM_OUT: zoom_q8 = clamp_signed(zoom_q8 - longint'(ZOOM_STEP), PIX_W);
               KEY_ZOOM_IN:  zoom_q8 = clamp_signed(zoom_q8 + longint'(ZOOM_STEP), PIX_W);
               KEY_LEFT:     ofs_x = clamp_signed(ofs_x - 1, PIX_W);
               KEY_RIGHT:    ofs_x = clamp_signed(ofs_x + 1, PIX_W);
               KEY_UP:       ofs_y = clamp_signed(ofs_y - 1, PIX_W);
               KEY_DOWN:     ofs_y = clamp_signed(ofs_y + 1, PIX_W);
               KEY_ROT_NEG:  rotate_figure(-longint'(SIN30_Q14));
               KEY_ROT_POS:  rotate_figure(longint'(SIN30_Q14));
               default: ;
            endcase
         end
         default: begin
            // draw: one result per stored point
            for (int i = 0; i < fig_count; i++) begin
               px = (to_whole(fig_x[i]) * zoom_q8) / 256 + ofs_x;
               py = (to_whole(fig_y[i]) * zoom_q8) / 256 + ofs_y;
               pix.pixel_x = PIX_W'(clamp_signed(px, PIX_W));
               pix.pixel_y = PIX_W'(clamp_signed(py, PIX_W));
               pix.visible = px >= 0 && px < SPRITE_COLS && py >= 0 && py < SPRITE_ROWS;
               pix.last = (i == fig_count - 1);
               pixel_expect_q.push_back(pix);
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= ERR_REPORT_MAX) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
         end
      end
   endtask

   // ---------------- monitor and model update ----------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fig_count = 0;
         zoom_q8 = longint'(ZOOM_ONE);
         ofs_x = 0;
         ofs_y = 0;
         piv_x = 0;
         piv_y = 0;
         for (int i = 0; i < DEF_MAX_POINTS; i++) begin
            fig_x[i] = 0;
            fig_y[i] = 0;
         end
      end else begin
         if (rsp_strobe) begin
            if (pixel_expect_q.size() == 0) begin
               mismatch_count++;
               $error("result transaction with no expected result pending");
            end else begin
               want = pixel_expect_q.pop_front();
               check_field("pixel_x", want.pixel_x, rsp_data.pixel_x);
               check_field("pixel_y", want.pixel_y, rsp_data.pixel_y);
               check_field("visible", want.visible, rsp_data.visible);
               check_field("last", want.last, rsp_data.last);
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_PIVOT_X) begin
               piv_x = longint'($signed(csr_wdata));
            end else if (csr_index == CSR_PIVOT_Y) begin
               piv_y = longint'($signed(csr_wdata));
            end
         end
         if (start && !busy) begin
            plot_predict(req_data);
            cmd_pend_q.delete(0);
         end
      end
   end

   // ---------------- driver ----------------
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (cmd_pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         start <= 1'b1;
         req_data <= cmd_pend_q[0];
      end else begin
         start <= 1'b0;
      end
   end

   // ---------------- stimulus ----------------
   function automatic req_type build_cmd(input logic [1:0] act, input logic [23:0] x,
                                         input logic [23:0] y, input logic [7:0] key);
      req_type r;
      r.action = act;
      r.point_x = x;
      r.point_y = y;
      r.key_code = key;
      return r;
   endfunction

   function automatic logic [23:0] rand_coord();
      int r;
      logic [23:0] edges [9];
      edges = '{24'h7FFFFF, 24'h800000, 24'h000080, 24'h000081, 24'hFFFF80,
                24'hFFFF7F, 24'h000000, 24'h004000, 24'h003FFF};
      r = $urandom_range(99);
      if (r < 60) begin
         return 24'(int'($urandom_range(80 * 256)) - 8 * 256);
      end else if (r < 80) begin
         return 24'($urandom());
      end
      return edges[$urandom_range(8)];
   endfunction

   function automatic req_type key_cmd(input logic [7:0] key);
      return build_cmd(ACT_KEY, 24'($urandom()), 24'($urandom()), key);
   endfunction

   function automatic req_type draw_cmd();
      return build_cmd(ACT_DRAW, 24'($urandom()), 24'($urandom()), 8'($urandom()));
   endfunction

   function automatic req_type point_cmd(input logic [23:0] x, input logic [23:0] y);
      return build_cmd(ACT_APPEND, x, y, 8'($urandom()));
   endfunction

   // queue one transaction; ignored ones (unknown key, append to a full store) are not counted
   task automatic queue_cmd(input req_type r);
      bit known;
      known = 0;
      foreach (KEY_SET[k]) begin
         if (KEY_SET[k] == r.key_code) known = 1;
      end
      case (r.action)
         ACT_CLEAR: begin
            gen_points = 0;
            counted_items++;
         end
         ACT_APPEND: begin
            if (gen_points < DEF_MAX_POINTS) begin
               gen_points++;
               counted_items++;
            end
         end
         ACT_KEY: if (known) counted_items++;
         default: counted_items++;
      endcase
      cmd_pend_q.push_back(r);
   endtask

   task automatic queue_directed();
      queue_cmd(draw_cmd());                              // empty store
      queue_cmd(key_cmd(8'h00));                          // unknown keys
      queue_cmd(key_cmd(8'hFF));
      queue_cmd(point_cmd(24'h000000, 24'h000000));
      queue_cmd(point_cmd(24'h7FFFFF, 24'h800000));
      queue_cmd(point_cmd(24'h000180, 24'h000181));       // fraction exactly half / just above
      queue_cmd(point_cmd(24'hFFFE80, 24'hFFFF00));       // negative truncates toward zero
      queue_cmd(point_cmd(24'(20 * 256 + 200), 24'(30 * 256 + 10)));
      queue_cmd(point_cmd(24'(64 * 256), 24'(63 * 256 + 100)));
      queue_cmd(draw_cmd());
      queue_cmd(key_cmd(KEY_ZOOM_IN));
      queue_cmd(key_cmd(KEY_ZOOM_OUT));
      queue_cmd(key_cmd(KEY_ZOOM_OUT));
      queue_cmd(key_cmd(KEY_RIGHT));
      queue_cmd(key_cmd(KEY_LEFT));
      queue_cmd(key_cmd(KEY_LEFT));
      queue_cmd(key_cmd(KEY_DOWN));
      queue_cmd(key_cmd(KEY_UP));
      queue_cmd(draw_cmd());
      queue_cmd(key_cmd(KEY_ROT_POS));
      queue_cmd(key_cmd(KEY_ROT_NEG));
      queue_cmd(key_cmd(KEY_ROT_NEG));
      queue_cmd(draw_cmd());
      queue_cmd(build_cmd(ACT_CLEAR, 24'($urandom()), 24'($urandom()), 8'($urandom())));
      queue_cmd(draw_cmd());                              // empty after clear
   endtask

   task automatic queue_repeat_key(input logic [7:0] key, input int n);
      repeat (n) queue_cmd(key_cmd(key));
   endtask

   // full store, appends past full, pixel rails, then zoom through zero into negative scale
   task automatic queue_saturation();
      for (int i = 0; i < DEF_MAX_POINTS + 2; i++) queue_cmd(point_cmd(rand_coord(), rand_coord()));
      queue_cmd(draw_cmd());
      queue_repeat_key(KEY_ZOOM_IN, 3);
      queue_cmd(draw_cmd());
      queue_repeat_key(KEY_ZOOM_OUT, 8);
      queue_cmd(draw_cmd());
      queue_repeat_key(KEY_ZOOM_IN, 5);
      queue_repeat_key(KEY_RIGHT, 3);
      queue_repeat_key(KEY_UP, 3);
      queue_cmd(key_cmd(KEY_ROT_POS));
      queue_cmd(draw_cmd());
   endtask

   // figure sessions: clear, load points, a mix of keys and draws, some noise
   task automatic queue_random(input int target);
      int goal, r, npts, nops;
      goal = counted_items + target;
      while (counted_items < goal) begin
         if ($urandom_range(99) < 80) begin
            queue_cmd(build_cmd(ACT_CLEAR, 24'($urandom()), 24'($urandom()), 8'($urandom())));
         end
         r = $urandom_range(99);
         npts = r < 70 ? $urandom_range(6, 1) : (r < 90 ? $urandom_range(20, 7)
                                                        : $urandom_range(68, 60));
         repeat (npts) queue_cmd(point_cmd(rand_coord(), rand_coord()));
         nops = $urandom_range(8, 2);
         repeat (nops) begin
            r = $urandom_range(99);
            if (r < 45) begin
               queue_cmd(key_cmd(KEY_SET[$urandom_range(7)]));
            end else if (r < 55) begin
               queue_cmd(key_cmd(8'($urandom())));
            end else if (r < 90) begin
               queue_cmd(draw_cmd());
            end else begin
               queue_cmd(build_cmd(2'($urandom()), 24'($urandom()), 24'($urandom()),
                                   8'($urandom())));
            end
         end
         queue_cmd(draw_cmd());
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // all transactions taken, results drained (bounded), then room for a rotation to finish
   task automatic settle();
      int n;
      while (cmd_pend_q.size() != 0) @(negedge clock);
      n = 0;
      while (pixel_expect_q.size() != 0 && n < DRAIN_CYCLES) begin
         @(negedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [COORD_W-1:0] pvx, pvy;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 4; ph++) begin
         if (ph != 0) settle();
         case (ph)
            0: begin pvx = 24'h001000; pvy = 24'hFFFD40; end
            1: begin pvx = 24'h7FFFFF; pvy = 24'h800000; end
            2: begin pvx = 24'h800000; pvy = 24'h7FFFFF; end
            default: begin
               pvx = 24'(int'($urandom_range(32768)) - 16384);
               pvy = 24'(int'($urandom_range(32768)) - 16384);
            end
         endcase
         csr_write(CSR_PIVOT_X, pvx);
         csr_write(CSR_PIVOT_Y, pvy);
         send_idle_pct = SEND_IDLE_PCT[ph];
         if (ph == 0) begin
            queue_directed();
            queue_saturation();
         end
         queue_random(PHASE_ITEMS);
      end
      settle();
      if (pixel_expect_q.size() != 0) begin
         mismatch_count++;
         $error("%0d expected results never arrived", pixel_expect_q.size());
      end
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ----- point_figure_rotate_scale_plot.f -----
+incdir+sv
sv/pfrsp_pkg.sv
sv/pfrsp_ram.sv
sv/pfrsp_mac.sv
sv/point_figure_rotate_scale_plot.sv
dv/tb_point_figure_rotate_scale_plot.sv
